[design/gsps_pkg.sv]
// Package for the grid shortest path search core.
// Holds sizes, register indexes, heap entry type and sequencer states.
// No dependencies.
`default_nettype none
package gsps_pkg;

  localparam int unsigned MaxWidth  = 64;
  localparam int unsigned MaxHeight = 64;
  localparam int unsigned DistBits  = 24;

  localparam int unsigned XW    = $clog2(MaxWidth);
  localparam int unsigned YW    = $clog2(MaxHeight);
  localparam int unsigned IdxW  = XW + YW;
  localparam int unsigned NPix  = MaxWidth * MaxHeight;
  localparam int unsigned CntW  = IdxW + 1;
  localparam int unsigned WgtW  = 8;
  localparam int unsigned CostW = WgtW + 1;

  localparam logic [16:0]         SQRT2_Q16 = 17'd92682;
  localparam logic [DistBits-1:0] DIST_MAX  = {DistBits{1'b1}};

  // configuration register indexes
  localparam logic [2:0] CFG_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_HEIGHT  = 3'd1;
  localparam logic [2:0] CFG_START_X = 3'd2;
  localparam logic [2:0] CFG_START_Y = 3'd3;

  // request kinds
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [DistBits-1:0] score;
    logic [IdxW-1:0]     idx;
  } heap_ent_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QRD,
    ST_CLR,
    ST_START,
    ST_POPCHK,
    ST_POPTOP,
    ST_POPLAST,
    ST_SDL,
    ST_SDR,
    ST_SDCMP,
    ST_NBNEXT,
    ST_NBEVAL,
    ST_SURD,
    ST_SUCMP
  } state_e;

endpackage
`default_nettype wire

[design/grid_shortest_path_search_top.sv]
// Grid shortest path search core: weight load, Dijkstra search, result query.
// Depends on gsps_pkg.
//
// channel  dir  handshake                 contents
// s_axis   in   s_axis_tvalid/tready      tdata px,py,weight,usable; tuser op; tlast
// m_axis   out  m_axis_tvalid/tready      tdata solved,is_start,pred_x,pred_y,distance
// cfg      in   cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i (taken only when idle)
//
// A load writes while idle; a query reads memory, then registers the result.
// The final load starts a clearing pass over the visited/queued memory, then
// the search: per pixel a pop with sift-down (left read, right read, compare
// per heap level) and eight neighbor slots (step, then evaluate if in grid),
// plus sift-up (parent read, compare per heap level) on each push or decrease;
// one heap read port carries all heap traffic and sets the search length.
// Reset is asynchronous, active low; memories are not reset. Until the first
// search has cleared the visited memory, every query reads as not solved.
// A waiting result blocks new requests unless it is taken in the same cycle.
`default_nettype none
module grid_shortest_path_search_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // px[5:0], py[11:6], weight[19:12], usable[20], zero pad [23:21]
  input  wire logic [23:0] s_axis_tdata,
  // op[0]
  input  wire logic        s_axis_tuser,
  input  wire logic        s_axis_tlast,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // solved[0], is_start[1], pred_x[7:2], pred_y[13:8], distance[37:14], pad [39:38]
  output      logic [39:0] m_axis_tdata,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [6:0]  cfg_data_i
);
  import gsps_pkg::*;

  // memories
  logic [WgtW:0]             wmem [NPix];   // {usable, weight}
  logic [1:0]                vmem [NPix];   // {visited, queued}
  logic [DistBits+IdxW-1:0]  dmem [NPix];   // {distance, predecessor}
  heap_ent_t                 hmem [NPix];
  logic [IdxW-1:0]           pmem [NPix];   // heap position per pixel

  logic                      wm_we, vm_we, dm_we, hm_we, pm_we;
  logic [IdxW-1:0]           wm_wa, vm_wa, dm_wa, hm_wa, pm_wa;
  logic [WgtW:0]             wm_wd;
  logic [1:0]                vm_wd;
  logic [DistBits+IdxW-1:0]  dm_wd;
  heap_ent_t                 hm_wd;
  logic [IdxW-1:0]           pm_wd;
  logic [IdxW-1:0]           wm_ra, vm_ra, dm_ra, hm_ra, pm_ra;
  logic [WgtW:0]             wm_rd;
  logic [1:0]                vm_rd;
  logic [DistBits+IdxW-1:0]  dm_rd;
  heap_ent_t                 hm_rd;
  logic [IdxW-1:0]           pm_rd;

  always_ff @(posedge clk_i) begin
    if (wm_we) wmem[wm_wa] <= wm_wd;
    wm_rd <= wmem[wm_ra];
  end
  always_ff @(posedge clk_i) begin
    if (vm_we) vmem[vm_wa] <= vm_wd;
    vm_rd <= vmem[vm_ra];
  end
  always_ff @(posedge clk_i) begin
    if (dm_we) dmem[dm_wa] <= dm_wd;
    dm_rd <= dmem[dm_ra];
  end
  always_ff @(posedge clk_i) begin
    if (hm_we) hmem[hm_wa] <= hm_wd;
    hm_rd <= hmem[hm_ra];
  end
  always_ff @(posedge clk_i) begin
    if (pm_we) pmem[pm_wa] <= pm_wd;
    pm_rd <= pmem[pm_ra];
  end

  // registers
  state_e           state_q, state_d;
  logic [6:0]       width_q, height_q;
  logic [XW-1:0]    sx_q;
  logic [YW-1:0]    sy_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [IdxW-1:0]  pos_q, pos_d;
  heap_ent_t        elem_q, elem_d;
  heap_ent_t        child_q, child_d;
  logic [IdxW-1:0]  cpos_q, cpos_d;
  logic             rok_q, rok_d;
  logic [IdxW-1:0]  cur_q, cur_d;
  logic [DistBits-1:0] score_q, score_d;
  logic [3:0]       k_q, k_d;
  logic [IdxW-1:0]  nb_q, nb_d;
  logic             diag_q, diag_d;
  logic [IdxW-1:0]  clr_q, clr_d;
  logic             ov_q, ov_d;
  logic [39:0]      od_q, od_d;
  logic             srun_q;        // visited memory valid once a search has cleared it

  // input fields
  logic [XW-1:0]    in_px;
  logic [YW-1:0]    in_py;
  logic [IdxW-1:0]  in_idx;
  logic             s_acc;
  assign in_px  = s_axis_tdata[5:0];
  assign in_py  = s_axis_tdata[11:6];
  assign in_idx = {in_py, in_px};
  assign s_acc  = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE) && (!ov_q || m_axis_tready);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign cfg_ready_o   = (state_q == ST_IDLE);

  // clamped grid size
  logic [6:0] ew, eh;
  always_comb begin
    ew = width_q;
    if (width_q == 7'd0) ew = 7'd1;
    else if (width_q > 7'(MaxWidth)) ew = 7'(MaxWidth);
    eh = height_q;
    if (height_q == 7'd0) eh = 7'd1;
    else if (height_q > 7'(MaxHeight)) eh = 7'(MaxHeight);
  end

  // neighbor slot k: rows top to bottom, columns left to right, center skipped
  logic [1:0]      dxs, dys;   // 0:-1, 1:0, 2:+1
  logic [7:0]      nx8, ny8;
  logic            nb_in;
  logic            nb_diag;
  logic [IdxW-1:0] nb_idx;
  always_comb begin
    unique case (k_q)
      4'd0: begin dxs = 2'd0; dys = 2'd0; end
      4'd1: begin dxs = 2'd1; dys = 2'd0; end
      4'd2: begin dxs = 2'd2; dys = 2'd0; end
      4'd3: begin dxs = 2'd0; dys = 2'd1; end
      4'd4: begin dxs = 2'd2; dys = 2'd1; end
      4'd5: begin dxs = 2'd0; dys = 2'd2; end
      4'd6: begin dxs = 2'd1; dys = 2'd2; end
      4'd7: begin dxs = 2'd2; dys = 2'd2; end
      default: begin dxs = 2'd1; dys = 2'd1; end
    endcase
    nx8 = 8'(cur_q[XW-1:0]) + 8'(dxs) - 8'd1;
    ny8 = 8'(cur_q[IdxW-1:XW]) + 8'(dys) - 8'd1;
    nb_in = !nx8[7] && !ny8[7] && (nx8[6:0] < ew) && (ny8[6:0] < eh);
    nb_diag = (dxs != 2'd1) && (dys != 2'd1);
    nb_idx = {ny8[YW-1:0], nx8[XW-1:0]};
  end

  // step cost and saturating score
  logic [24:0]         prod;
  logic [CostW-1:0]    cost;
  logic [DistBits:0]   sum;
  logic [DistBits-1:0] sc;
  heap_ent_t           new_ent;
  always_comb begin
    prod = 25'(wm_rd[WgtW-1:0]) * 25'(SQRT2_Q16);
    cost = diag_q ? prod[24:16] : CostW'(wm_rd[WgtW-1:0]);
    sum  = (DistBits+1)'(score_q) + (DistBits+1)'(cost);
    sc   = sum[DistBits] ? DIST_MAX : sum[DistBits-1:0];
    new_ent = '{score: sc, idx: nb_q};
  end

  // heap index arithmetic
  logic [CntW-1:0] ln, rn;
  logic [IdxW-1:0] par;
  logic [CntW-1:0] cnt_m1;
  assign ln     = {pos_q, 1'b1};
  assign rn     = ln + CntW'(1);
  assign par    = (pos_q - IdxW'(1)) >> 1;
  assign cnt_m1 = cnt_q - CntW'(1);

  logic [IdxW-1:0] start_idx;
  logic            start_out;
  assign start_idx = {sy_q, sx_q};
  assign start_out = (7'(sx_q) >= ew) || (7'(sy_q) >= eh);

  // sift-down choice
  logic      sd_move;
  heap_ent_t sd_best;
  logic [IdxW-1:0] sd_bpos;
  always_comb begin
    sd_move = 1'b0;
    sd_best = elem_q;
    sd_bpos = cpos_q;
    if (child_q < elem_q) begin
      sd_move = 1'b1;
      sd_best = child_q;
    end
    if (rok_q && (hm_rd < sd_best)) begin
      sd_move = 1'b1;
      sd_best = hm_rd;
      sd_bpos = rn[IdxW-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          if (s_axis_tuser == OP_QUERY) state_d = ST_QRD;
          else if (s_axis_tlast) state_d = ST_CLR;
        end
      end
      ST_QRD:     state_d = ST_IDLE;
      ST_CLR:     if (clr_q == IdxW'(NPix - 1)) state_d = ST_START;
      ST_START:   state_d = start_out ? ST_IDLE : ST_SURD;
      ST_POPCHK:  state_d = (cnt_q == '0) ? ST_IDLE : ST_POPTOP;
      ST_POPTOP:  state_d = (cnt_q > CntW'(1)) ? ST_POPLAST : ST_NBNEXT;
      ST_POPLAST: state_d = ST_SDL;
      ST_SDL:     state_d = (ln >= cnt_q) ? ST_NBNEXT : ST_SDR;
      ST_SDR:     state_d = ST_SDCMP;
      ST_SDCMP:   state_d = sd_move ? ST_SDL : ST_NBNEXT;
      ST_NBNEXT: begin
        if (k_q == 4'd8) state_d = ST_POPCHK;
        else if (nb_in) state_d = ST_NBEVAL;
      end
      ST_NBEVAL: begin
        if (vm_rd[1] || !wm_rd[WgtW]) state_d = ST_NBNEXT;
        else if (!vm_rd[0]) state_d = ST_SURD;
        else if (sc < dm_rd[DistBits+IdxW-1:IdxW]) state_d = ST_SURD;
        else state_d = ST_NBNEXT;
      end
      ST_SURD:    state_d = (pos_q == '0) ? ST_NBNEXT : ST_SUCMP;
      ST_SUCMP:   state_d = (elem_q < hm_rd) ? ST_SURD : ST_NBNEXT;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath and memory ports
  always_comb begin
    cnt_d = cnt_q;   pos_d = pos_q;   elem_d = elem_q; child_d = child_q;
    cpos_d = cpos_q; rok_d = rok_q;   cur_d = cur_q;   score_d = score_q;
    k_d = k_q;       nb_d = nb_q;     diag_d = diag_q; clr_d = clr_q;
    ov_d = ov_q;     od_d = od_q;
    wm_we = 1'b0; wm_wa = in_idx; wm_wd = {s_axis_tdata[20], s_axis_tdata[19:12]};
    vm_we = 1'b0; vm_wa = clr_q;  vm_wd = 2'b00;
    dm_we = 1'b0; dm_wa = nb_q;   dm_wd = {sc, cur_q};
    hm_we = 1'b0; hm_wa = pos_q;  hm_wd = elem_q;
    pm_we = 1'b0; pm_wa = elem_q.idx; pm_wd = pos_q;
    wm_ra = nb_idx;
    vm_ra = (state_q == ST_IDLE) ? in_idx : nb_idx;
    dm_ra = (state_q == ST_IDLE) ? in_idx : nb_idx;
    pm_ra = nb_idx;
    hm_ra = '0;

    if (ov_q && m_axis_tready) ov_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        clr_d = '0;
        if (s_acc && (s_axis_tuser == OP_LOAD)) wm_we = 1'b1;
      end
      ST_QRD: begin
        ov_d = 1'b1;
        od_d = '0;
        if (srun_q && vm_rd[1]) begin
          od_d[0] = 1'b1;
          if (dm_rd[IdxW-1:0] == cur_q) od_d[1] = 1'b1;
          else od_d[13:2] = dm_rd[IdxW-1:0];
          od_d[37:14] = dm_rd[DistBits+IdxW-1:IdxW];
        end
      end
      ST_CLR: begin
        vm_we = 1'b1;
        clr_d = clr_q + IdxW'(1);
        cnt_d = '0;
      end
      ST_START: begin
        if (!start_out) begin
          vm_we = 1'b1; vm_wa = start_idx; vm_wd = 2'b01;
          dm_we = 1'b1; dm_wa = start_idx; dm_wd = {{DistBits{1'b0}}, start_idx};
          elem_d = '{score: '0, idx: start_idx};
          pos_d = '0;
          cnt_d = CntW'(1);
          k_d = 4'd8;
        end
      end
      ST_POPCHK: hm_ra = '0;
      ST_POPTOP: begin
        cur_d = hm_rd.idx;
        score_d = hm_rd.score;
        vm_we = 1'b1; vm_wa = hm_rd.idx; vm_wd = 2'b11;
        cnt_d = cnt_m1;
        k_d = 4'd0;
        hm_ra = cnt_m1[IdxW-1:0];
      end
      ST_POPLAST: begin
        elem_d = hm_rd;
        pos_d = '0;
      end
      ST_SDL: begin
        hm_ra = ln[IdxW-1:0];
        if (ln >= cnt_q) begin
          hm_we = 1'b1; pm_we = 1'b1;
        end
      end
      ST_SDR: begin
        hm_ra = rn[IdxW-1:0];
        child_d = hm_rd;
        cpos_d = ln[IdxW-1:0];
        rok_d = rn < cnt_q;
      end
      ST_SDCMP: begin
        hm_we = 1'b1; pm_we = 1'b1;
        if (sd_move) begin
          hm_wd = sd_best; pm_wa = sd_best.idx;
          pos_d = sd_bpos;
        end
      end
      ST_NBNEXT: begin
        if (k_q != 4'd8) begin
          k_d = k_q + 4'd1;
          nb_d = nb_idx;
          diag_d = nb_diag;
        end
      end
      ST_NBEVAL: begin
        if (!(vm_rd[1] || !wm_rd[WgtW])) begin
          if (!vm_rd[0]) begin
            vm_we = 1'b1; vm_wa = nb_q; vm_wd = 2'b01;
            dm_we = 1'b1;
            elem_d = new_ent;
            pos_d = cnt_q[IdxW-1:0];
            cnt_d = cnt_q + CntW'(1);
          end else if (sc < dm_rd[DistBits+IdxW-1:IdxW]) begin
            dm_we = 1'b1;
            elem_d = new_ent;
            pos_d = pm_rd;
          end
        end
      end
      ST_SURD: begin
        hm_ra = par;
        if (pos_q == '0) begin
          hm_we = 1'b1; pm_we = 1'b1;
        end
      end
      ST_SUCMP: begin
        hm_we = 1'b1; pm_we = 1'b1;
        if (elem_q < hm_rd) begin
          hm_wd = hm_rd; pm_wa = hm_rd.idx;
          pos_d = par;
        end
      end
      default: ;
    endcase

    // query pixel kept in cur for the is_start compare
    if (state_q == ST_IDLE && s_acc && (s_axis_tuser == OP_QUERY)) cur_d = in_idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      width_q  <= 7'(MaxWidth);
      height_q <= 7'(MaxHeight);
      sx_q     <= '0;
      sy_q     <= '0;
      cnt_q    <= '0;
      k_q      <= '0;
      clr_q    <= '0;
      ov_q     <= 1'b0;
      srun_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
      if (state_q == ST_CLR) srun_q <= 1'b1;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_WIDTH:   width_q  <= cfg_data_i;
          CFG_HEIGHT:  height_q <= cfg_data_i;
          CFG_START_X: sx_q     <= cfg_data_i[XW-1:0];
          CFG_START_Y: sy_q     <= cfg_data_i[YW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    elem_q  <= elem_d;
    child_q <= child_d;
    cpos_q  <= cpos_d;
    rok_q   <= rok_d;
    cur_q   <= cur_d;
    score_q <= score_d;
    nb_q    <= nb_d;
    diag_q  <= diag_d;
    od_q    <= od_d;
  end

endmodule
`default_nettype wire
